// File: hw/rtl/wfsa_pkg.sv
// Package: shared types, codes and defaults of the worst-fit segment allocator.
`timescale 1ns / 1ps
package wfsa_pkg;

  localparam int HOLE_ENTRIES_DEF = 32;
  localparam int PAGE_BYTES_DEF   = 256;
  localparam int ADDR_W           = 24;
  localparam int USED_W           = 25;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 24'h3FFFFF;
  localparam logic [ADDR_W-1:0] HEAP_SIZE_RST = 24'hFFFFFF - 24'h3FFFFF;
  localparam logic [USED_W-1:0] USED_MAX      = 25'h1FFFFFF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [1:0] CFG_HEAP_SIZE = 2'd1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] request_size;
  } wfsa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;
    logic [USED_W-1:0] used_total;
  } wfsa_out_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_IDLE,
    S_ROUND,
    S_SCAN_A,
    S_SCAN_R,
    S_MERGE
  } wfsa_state_t;

endpackage

// File: hw/rtl/worst_fit_segment_allocator.sv
// Top level: worst-fit free-hole allocator with release coalescing.
//
//   channel  | ports                                | handshake
//   ---------+--------------------------------------+------------------------------
//   input    | start, busy, in_data                 | taken when start && !busy
//   result   | out_valid, out_data                  | one-cycle strobe, no stall
//   config   | cfg_valid, cfg_ready, cfg_index/data | taken when valid && ready
//
// Each item first rounds its size up to whole pages: a multiply by the
// page-size reciprocal, then a multiply back by the page size. An allocate
// then scans the hole table once through the single read port of the hole
// memory; the result strobe comes in the cycle after the scan ends, and the
// next item is taken at the end of that cycle. A release scans until a
// touching hole is found, then runs merge passes over the table, one per
// merge plus a final clean pass. Reset and every write to heap_base or
// heap_size pass through the load state, which rebuilds the table as a
// single hole; cfg_ready drops while start is high in idle, so an item
// always wins over a config write. The receiver cannot stall: the result
// register is updated only in the cycle an item finishes.
`timescale 1ns / 1ps
module worst_fit_segment_allocator
  import wfsa_pkg::*;
#(
  parameter int HOLE_ENTRIES = HOLE_ENTRIES_DEF,
  parameter int PAGE_BYTES   = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wfsa_in_t          in_data,
  output logic              out_valid,
  output wfsa_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int IW = (HOLE_ENTRIES > 1) ? $clog2(HOLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(HOLE_ENTRIES);

  // page rounding: quotient = (size + PAGE_BYTES - 1) * RECIP >> RK, exact for
  // every 25-bit dividend since RECIP = ceil(2^RK / PAGE_BYTES)
  localparam int     RK      = USED_W + $clog2(PAGE_BYTES);
  localparam int     MW      = USED_W + 2;
  localparam int     PRW     = USED_W + MW;
  localparam longint RECIP_L = ((longint'(1) << RK) + longint'(PAGE_BYTES - 1))
                               / longint'(PAGE_BYTES);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  wfsa_state_t state_r, state_nxt;

  // configuration
  logic [ADDR_W-1:0] heap_base_r, heap_size_r;
  logic              cfg_wr, cfg_reload;

  // hole memory: {base, length}
  logic [2*ADDR_W-1:0] mem [HOLE_ENTRIES];
  logic [2*ADDR_W-1:0] rd_q;
  logic [IW-1:0]       rd_addr;
  logic                we;
  logic [IW-1:0]       wa;
  logic [2*ADDR_W-1:0] wd;
  logic [HOLE_ENTRIES-1:0] valid_r;

  // request and rounding
  wfsa_in_t          in_r;
  logic              rnd_ph_r;
  logic [USED_W-1:0] round_m;
  logic [PRW-1:0]    prod_r;
  logic [USED_W-1:0] quo;
  logic [USED_W-1:0] r_r, r_nxt;

  // scan pipeline
  logic [CW-1:0] iss_r;
  logic          pv_r;
  logic [IW-1:0] pidx_r;
  logic          scan_done, restart, item_done;

  // scan trackers
  logic              best_v_r;
  logic [IW-1:0]     best_idx_r;
  logic [ADDR_W-1:0] best_base_r, best_len_r;
  logic              free_v_r;
  logic [IW-1:0]     free_idx_r;
  logic [IW-1:0]     cur_r;
  logic [ADDR_W-1:0] cur_base_r, cur_len_r;

  logic [USED_W-1:0] used_r;
  logic              out_valid_r;
  wfsa_out_t         out_r;

  // entry under evaluation
  logic [ADDR_W-1:0] eb, el;
  logic              ev;
  logic [USED_W-1:0] end_j, cur_end;
  logic [USED_W:0]   rel_end, sum_jr;
  logic [USED_W-1:0] sum_jc;
  logic [ADDR_W-1:0] sat_jr, sat_jc;
  logic              rel_hit, mrg_a, mrg_b, alloc_fail;
  logic [USED_W:0]   used_add;

  assign cfg_wr     = cfg_valid && cfg_ready;
  assign cfg_reload = cfg_wr && (cfg_index == CFG_HEAP_BASE || cfg_index == CFG_HEAP_SIZE);

  assign eb      = rd_q[2*ADDR_W-1:ADDR_W];
  assign el      = rd_q[ADDR_W-1:0];
  assign ev      = pv_r && valid_r[pidx_r];
  assign end_j   = {1'b0, eb} + {1'b0, el};
  assign cur_end = {1'b0, cur_base_r} + {1'b0, cur_len_r};
  assign rel_end = {2'b0, in_r.address} + {1'b0, r_r};
  assign sum_jr  = {2'b0, el} + {1'b0, r_r};
  assign sum_jc  = {1'b0, el} + {1'b0, cur_len_r};
  assign sat_jr  = (sum_jr[USED_W:ADDR_W] != '0) ? '1 : sum_jr[ADDR_W-1:0];
  assign sat_jc  = sum_jc[ADDR_W] ? '1 : sum_jc[ADDR_W-1:0];

  assign rel_hit = ev && (end_j == {1'b0, in_r.address} || rel_end == {2'b0, eb});
  assign mrg_a   = ev && (pidx_r != cur_r) && (end_j == {1'b0, cur_base_r});
  assign mrg_b   = ev && (pidx_r != cur_r) && !mrg_a && (cur_end == {1'b0, eb});

  assign scan_done  = (iss_r == LAST_CNT) && !pv_r;
  assign alloc_fail = !best_v_r || ({1'b0, best_len_r} < r_r);
  assign used_add   = {1'b0, used_r} + {1'b0, r_r};

  // round up to pages: reciprocal multiply, then multiply back by the page size
  assign round_m = {1'b0, in_r.request_size} + USED_W'(PAGE_BYTES - 1);
  assign quo     = USED_W'(prod_r >> RK);
  assign r_nxt   = quo * USED_W'(PAGE_BYTES);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:   state_nxt = cfg_reload ? S_LOAD : S_IDLE;
      S_IDLE: begin
        if (cfg_reload)
          state_nxt = S_LOAD;
        else if (start)
          state_nxt = S_ROUND;
      end
      S_ROUND: begin
        if (rnd_ph_r)
          state_nxt = (in_r.opcode == OP_ALLOC) ? S_SCAN_A : S_SCAN_R;
      end
      S_SCAN_A: if (scan_done) state_nxt = S_IDLE;
      S_SCAN_R: begin
        if (rel_hit)
          state_nxt = S_MERGE;
        else if (scan_done)
          state_nxt = S_IDLE;
      end
      S_MERGE:  if (scan_done) state_nxt = S_IDLE;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // outputs and memory write decode
  always_comb begin
    busy      = (state_r != S_IDLE);
    cfg_ready = (state_r == S_LOAD) || ((state_r == S_IDLE) && !start);
    rd_addr   = iss_r[IW-1:0];
    restart   = 1'b0;
    item_done = 1'b0;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    unique case (state_r)
      S_LOAD: begin
        we = 1'b1;
        wd = {heap_base_r, heap_size_r};
      end
      S_ROUND: begin
        // start the scan from entry zero once the rounded size is ready
        restart = rnd_ph_r;
      end
      S_SCAN_A: begin
        item_done = scan_done;
        if (scan_done && !alloc_fail) begin
          we = 1'b1;
          wa = best_idx_r;
          wd = {best_base_r + r_r[ADDR_W-1:0], best_len_r - r_r[ADDR_W-1:0]};
        end
      end
      S_SCAN_R: begin
        if (rel_hit) begin
          restart = 1'b1;
          we      = 1'b1;
          wa      = pidx_r;
          wd      = {(end_j == {1'b0, in_r.address}) ? eb : in_r.address, sat_jr};
        end else if (scan_done) begin
          item_done = 1'b1;
          if (free_v_r) begin
            we = 1'b1;
            wa = free_idx_r;
            wd = {in_r.address, (r_r[ADDR_W] ? {ADDR_W{1'b1}} : r_r[ADDR_W-1:0])};
          end
        end
      end
      S_MERGE: begin
        if (mrg_a) begin
          restart = 1'b1;
          we      = 1'b1;
          wa      = pidx_r;
          wd      = {eb, sat_jc};
        end else if (mrg_b) begin
          restart = 1'b1;
          we      = 1'b1;
          wa      = cur_r;
          wd      = {cur_base_r, sat_jc};
        end else if (scan_done) begin
          item_done = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // hole memory
  always_ff @(posedge clk) begin
    if (we)
      mem[wa] <= wd;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      heap_base_r <= HEAP_BASE_RST;
      heap_size_r <= HEAP_SIZE_RST;
      valid_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= item_done;
      if (cfg_wr && cfg_index == CFG_HEAP_BASE)
        heap_base_r <= cfg_data;
      if (cfg_wr && cfg_index == CFG_HEAP_SIZE)
        heap_size_r <= cfg_data;

      // advance the scan pipeline; drop the in-flight read on a restart
      if (restart) begin
        iss_r <= '0;
        pv_r  <= 1'b0;
      end else if (iss_r != LAST_CNT) begin
        iss_r  <= iss_r + CW'(1);
        pv_r   <= 1'b1;
        pidx_r <= iss_r[IW-1:0];
      end else begin
        pv_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          valid_r <= HOLE_ENTRIES'(1);
          used_r  <= '0;
        end
        S_IDLE: begin
          if (start && !cfg_reload) begin
            in_r     <= in_data;
            rnd_ph_r <= 1'b0;
          end
        end
        S_ROUND: begin
          if (!rnd_ph_r) begin
            prod_r   <= PRW'(round_m) * PRW'(RECIP);
            rnd_ph_r <= 1'b1;
          end else begin
            r_r      <= r_nxt;
            best_v_r <= 1'b0;
            free_v_r <= 1'b0;
          end
        end
        S_SCAN_A: begin
          if (ev && (!best_v_r || el > best_len_r)) begin
            best_v_r    <= 1'b1;
            best_idx_r  <= pidx_r;
            best_base_r <= eb;
            best_len_r  <= el;
          end
          if (scan_done) begin
            if (alloc_fail) begin
              out_r <= '{status: ST_NOSPACE, granted_address: '0, used_total: used_r};
            end else begin
              if (best_len_r == r_r[ADDR_W-1:0])
                valid_r[best_idx_r] <= 1'b0;
              used_r <= used_add[USED_W] ? USED_MAX : used_add[USED_W-1:0];
              out_r  <= '{status: ST_OK, granted_address: best_base_r,
                          used_total: used_add[USED_W] ? USED_MAX : used_add[USED_W-1:0]};
            end
          end
        end
        S_SCAN_R: begin
          if (pv_r && !valid_r[pidx_r] && !free_v_r) begin
            free_v_r   <= 1'b1;
            free_idx_r <= pidx_r;
          end
          if (rel_hit) begin
            cur_r      <= pidx_r;
            cur_base_r <= (end_j == {1'b0, in_r.address}) ? eb : in_r.address;
            cur_len_r  <= sat_jr;
          end else if (scan_done) begin
            if (free_v_r) begin
              valid_r[free_idx_r] <= 1'b1;
              used_r <= (used_r > r_r) ? used_r - r_r : '0;
              out_r  <= '{status: ST_OK, granted_address: '0,
                          used_total: (used_r > r_r) ? used_r - r_r : '0};
            end else begin
              out_r <= '{status: ST_FULL, granted_address: '0, used_total: used_r};
            end
          end
        end
        S_MERGE: begin
          if (mrg_a) begin
            valid_r[cur_r] <= 1'b0;
            cur_r          <= pidx_r;
            cur_base_r     <= eb;
            cur_len_r      <= sat_jc;
          end else if (mrg_b) begin
            valid_r[pidx_r] <= 1'b0;
            cur_len_r       <= sat_jc;
          end else if (scan_done) begin
            used_r <= (used_r > r_r) ? used_r - r_r : '0;
            out_r  <= '{status: ST_OK, granted_address: '0,
                        used_total: (used_r > r_r) ? used_r - r_r : '0};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result reports the running count as it stands after the item
  a_used_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.used_total == used_r)
    else $error("result count differs from running count");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.granted_address == '0)
    else $error("failed item carries an address");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !cfg_reload |=> busy)
    else $error("accepted item did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result without work in progress");

endmodule

// File: sim/tb_worst_fit_segment_allocator.sv
// Testbench: self-checking random and directed test of the worst-fit segment allocator.
`timescale 1ns / 1ps
module tb_worst_fit_segment_allocator;
  import wfsa_pkg::*;

  localparam int  NHOLE     = HOLE_ENTRIES_DEF;
  localparam int  PG        = PAGE_BYTES_DEF;
  localparam int  IDLE_STOP = 20000;   // cycles without any handshake before giving up
  localparam logic [23:0] AMASK = 24'hFFFFFF;

  typedef struct {
    logic [23:0] base;
    logic [23:0] len;
  } live_blk_t;

  // Scoreboard: mirrors the hole table, predicts one result per accepted item
  // and checks results in order.
  class hole_table_sb;
    bit          vld[NHOLE];
    logic [23:0] hbase[NHOLE];
    logic [23:0] hlen[NHOLE];
    logic [24:0] used;
    logic [23:0] reg_base;
    logic [23:0] reg_size;
    wfsa_out_t   expected_q[$];
    live_blk_t   granted_q[$];   // blocks handed out, for well-formed releases
    int          errors;

    function new();
      reg_base = HEAP_BASE_RST;
      reg_size = HEAP_SIZE_RST;
      errors   = 0;
      reload();
    endfunction

    function void reload();
      for (int i = 0; i < NHOLE; i++) begin
        vld[i] = 0; hbase[i] = '0; hlen[i] = '0;
      end
      vld[0] = 1; hbase[0] = reg_base; hlen[0] = reg_size;
      used = '0;
      granted_q.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == CFG_HEAP_BASE) reg_base = val;
      else if (idx == CFG_HEAP_SIZE) reg_size = val;
      else return;
      reload();
    endfunction

    function logic [23:0] sat(longint v);
      return (v > longint'(AMASK)) ? AMASK : v[23:0];
    endfunction

    function longint hend(int i);
      return longint'(hbase[i]) + longint'(hlen[i]);
    endfunction

    // Coalesce every hole touching entry cur until nothing changes.
    function void coalesce(int cur);
      bit chg;
      chg = 1;
      while (chg) begin
        chg = 0;
        for (int j = 0; j < NHOLE; j++) begin
          if (!vld[j] || j == cur) continue;
          if (hend(j) == longint'(hbase[cur])) begin
            hlen[j] = sat(longint'(hlen[j]) + longint'(hlen[cur]));
            vld[cur] = 0; cur = j; chg = 1;
            break;
          end
          if (hend(cur) == longint'(hbase[j])) begin
            hlen[cur] = sat(longint'(hlen[cur]) + longint'(hlen[j]));
            vld[j] = 0; chg = 1;
            break;
          end
        end
      end
    endfunction

    function void note_item(wfsa_in_t it);
      longint    r;
      longint    u;
      int        best;
      int        hit;
      int        k;
      wfsa_out_t res;
      live_blk_t b;
      r   = ((longint'(it.request_size) + PG - 1) / PG) * PG;
      res = '0;
      res.status = ST_OK;
      if (it.opcode == OP_ALLOC) begin
        best = -1;
        for (int i = 0; i < NHOLE; i++)
          if (vld[i] && (best < 0 || hlen[i] > hlen[best])) best = i;
        if (best < 0 || longint'(hlen[best]) < r) begin
          res.status = ST_NOSPACE;
        end else begin
          res.granted_address = hbase[best];
          if (longint'(hlen[best]) == r) begin
            vld[best] = 0;
          end else begin
            hlen[best]  = hlen[best] - r[23:0];
            hbase[best] = hbase[best] + r[23:0];
          end
          u = longint'(used) + r;
          used = (u > longint'(USED_MAX)) ? USED_MAX : u[24:0];
          if (r > 0) begin
            b.base = res.granted_address; b.len = r[23:0];
            granted_q.push_back(b);
          end
        end
      end else begin
        hit = -1;
        for (int i = 0; i < NHOLE; i++) begin
          if (!vld[i]) continue;
          if (hend(i) == longint'(it.address)) begin
            hlen[i] = sat(longint'(hlen[i]) + r);
            hit = i;
            break;
          end
          if (longint'(it.address) + r == longint'(hbase[i])) begin
            hbase[i] = it.address;
            hlen[i]  = sat(longint'(hlen[i]) + r);
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          coalesce(hit);
        end else begin
          k = NHOLE;
          for (int i = 0; i < NHOLE; i++)
            if (!vld[i]) begin k = i; break; end
          if (k < NHOLE) begin
            vld[k] = 1; hbase[k] = it.address; hlen[k] = sat(r);
          end else begin
            res.status = ST_FULL;
          end
        end
        if (res.status == ST_OK)
          used = (longint'(used) > r) ? used - r[24:0] : '0;
      end
      res.used_total = used;
      expected_q.push_back(res);
    endfunction

    function void check_result(wfsa_out_t got);
      wfsa_out_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: %p", got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.granted_address !== exp_r.granted_address) begin
        $error("granted_address: expected %h, actual %h",
               exp_r.granted_address, got.granted_address);
        errors++;
      end
      if (got.used_total !== exp_r.used_total) begin
        $error("used_total: expected %h, actual %h", exp_r.used_total, got.used_total);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  wfsa_in_t    in_data = '0;
  logic        out_valid;
  wfsa_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HEAP_BASE;
  logic [23:0] cfg_data = '0;

  hole_table_sb sb = new();
  int           quiet_cycles = 0;

  always #2 clk = ~clk;

  worst_fit_segment_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Monitor: check results before noting a new item taken at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_item(in_data);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Watchdog: reset the count on any handshake, give up after a long silence.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_STOP) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold start high until the item is taken; the caller drops start in gaps.
  task automatic send_item(logic op, logic [23:0] addr, logic [23:0] size);
    wfsa_in_t it;
    it.opcode = op; it.address = addr; it.request_size = size;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  // A zero-length gap keeps start high for back-to-back items.
  task automatic gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait for every outstanding result, then give the block a few spare cycles.
  task automatic drain();
    gap(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_heap(logic [23:0] b, logic [23:0] s);
    drain();
    write_cfg(CFG_HEAP_BASE, b);
    write_cfg(CFG_HEAP_SIZE, s);
  endtask

  // One random item: mostly allocates and well-formed releases of granted
  // blocks, the rest noise releases with a random address and size.
  task automatic random_item();
    int        sel;
    int        k;
    live_blk_t b;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      if ($urandom_range(0, 9) == 0)
        send_item(OP_ALLOC, 24'($urandom()), 24'($urandom()));
      else
        send_item(OP_ALLOC, 24'($urandom()), 24'($urandom_range(0, 8 * PG)));
    end else if (sel < 88 && sb.granted_q.size() != 0) begin
      k = $urandom_range(0, sb.granted_q.size() - 1);
      b = sb.granted_q[k];
      sb.granted_q.delete(k);
      // release with the exact size or the smallest size that rounds up to it
      send_item(OP_RELEASE, b.base,
                ($urandom_range(0, 1) == 1 && b.len > PG) ? b.len - 24'(PG - 1) : b.len);
    end else begin
      send_item(OP_RELEASE, 24'($urandom()), ($urandom_range(0, 3) == 0) ?
                24'($urandom()) : 24'($urandom_range(0, 4 * PG)));
    end
  endtask

  task automatic random_phase(int n);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        random_item();
        burst--; left--;
      end
      // bursts back to back, mostly followed by a short random gap
      if ($urandom_range(0, 3) != 0) gap($urandom_range(0, 7));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset heap, field extremes, zero sizes, unallocated release.
    send_item(OP_ALLOC, 24'h000000, 24'h000000);
    send_item(OP_ALLOC, AMASK, 24'h000001);
    send_item(OP_ALLOC, 24'h000000, AMASK);           // rounds past 24 bits
    send_item(OP_ALLOC, 24'h000000, 24'h000100);
    send_item(OP_RELEASE, 24'h3FFFFF, 24'h000001);     // touches no hole, takes a free entry
    send_item(OP_RELEASE, 24'h400000, 24'h000100);
    send_item(OP_RELEASE, 24'h000000, 24'h000100);     // never allocated
    send_item(OP_RELEASE, AMASK, AMASK);               // saturated length
    send_item(OP_ALLOC, 24'h000000, AMASK);
    gap(3);

    // Ties, exact fit and a zero-length hole.
    set_heap(24'h000000, 24'h000200);
    send_item(OP_ALLOC, 24'h0, 24'h000200);            // exact fit empties table
    send_item(OP_ALLOC, 24'h0, 24'h000000);            // no valid hole
    send_item(OP_RELEASE, 24'h000400, 24'h000100);
    send_item(OP_RELEASE, 24'h000800, 24'h000100);     // tie with the hole above
    send_item(OP_ALLOC, 24'h0, 24'h000080);
    send_item(OP_RELEASE, 24'h000500, 24'h000300);     // bridge, then merge
    set_heap(AMASK, 24'h000000);
    send_item(OP_ALLOC, 24'h0, 24'h000000);            // zero-length hole freed
    send_item(OP_RELEASE, AMASK, 24'h000100);          // end past 24 bits

    // Fill the table with scattered releases until it reports full.
    set_heap(24'h000000, 24'h001000);
    for (int i = 0; i < 36; i++)
      send_item(OP_RELEASE, 24'(24'h100000 + i * 24'h1000), 24'(PG));
    random_phase(60);

    set_heap(24'h000000, AMASK);
    random_phase(120);
    set_heap(24'hFFF000, 24'h000FFF);
    random_phase(50);
    set_heap(24'($urandom()), 24'($urandom()));
    random_phase(85);
    set_heap(HEAP_BASE_RST, HEAP_SIZE_RST);
    random_phase(85);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wfsa_pkg.sv
hw/rtl/worst_fit_segment_allocator.sv
sim/tb_worst_fit_segment_allocator.sv
